// ===== rtl/crc32_record_framer_checker_macros.svh =====
// Assertion macros shared by the record framer RTL.
`ifndef CRC32_RECORD_FRAMER_CHECKER_MACROS_SVH
`define CRC32_RECORD_FRAMER_CHECKER_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication.
`define CRCRF_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// Next-cycle implication.
`define CRCRF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`else

`define CRCRF_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define CRCRF_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== rtl/crcrf_pkg.sv =====
`default_nettype none

package crcrf_pkg;

   // Reflected CRC-32 constants.
   localparam logic [31:0] CRC_POLY = 32'hEDB88320;
   localparam logic [31:0] CRC_ONES = 32'hFFFFFFFF;

   // Configuration register indexes.
   localparam logic CSR_MODE       = 1'b0;
   localparam logic CSR_RECORD_LEN = 1'b1;

   // Operating modes.
   localparam logic MODE_CHECK  = 1'b0;
   localparam logic MODE_APPEND = 1'b1;

   // Result kinds.
   localparam logic KIND_DATA   = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   // Status codes.
   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_CLEAN   = 2'd1;
   localparam logic [1:0] STATUS_CORRUPT = 2'd2;

   // Reset value of the record length register.
   localparam logic [12:0] RECORD_LEN_RESET = 13'd64;

   // One input beat.
   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_stream;
   } crcrf_req_type;

   // One result beat.
   typedef struct packed {
      logic        kind;
      logic [7:0]  out_byte;
      logic [1:0]  status;
      logic [31:0] crc_value;
      logic        last;
   } crcrf_rsp_type;

   // What one accepted input left to deliver.
   typedef enum logic [1:0] {
      BND_DATA,
      BND_CRC,
      BND_STATUS
   } crcrf_bnd_type;

   // One byte step of the reflected CRC register.
   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] data);
      logic [31:0] c;
      c = crc ^ {24'd0, data};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
      end
      return c;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/crc32_record_framer_checker.sv =====
// The first result of an input beat is offered in the cycle after it is accepted;
// the first three trailer bytes of a check-mode record give no result at all.
// One byte per cycle while results are not stalled; an append-mode last payload byte
// gives five result beats, one per unstalled cycle; input stalls until the last is out.
// Reset (synchronous, active high): mode check, record length 64, CRC all ones,
// record position and trailer cleared, no result pending.
`default_nettype none

`include "crc32_record_framer_checker_macros.svh"

module crc32_record_framer_checker
   import crcrf_pkg::*;
#(
   parameter int MAX_RECORD_LEN = 4096
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output      logic          req_stall,
   input  wire crcrf_req_type req_data,
   output      logic          rsp_valid,
   input  wire logic          rsp_stall,
   output      crcrf_rsp_type rsp_data,
   input  wire logic          csr_valid,
   output      logic          csr_ready,
   input  wire logic          csr_index,
   input  wire logic [12:0]   csr_data
);

   // Position counts payload plus up to four trailer bytes.
   localparam int POS_W = $clog2(MAX_RECORD_LEN + 4);

   logic              mode_ff;
   logic [12:0]       record_len_ff;
   logic [31:0]       crc_ff, crc_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [31:0]       trl_ff, trl_in;

   logic              bnd_valid_ff, bnd_valid_in;
   crcrf_bnd_type     bnd_kind_ff, bnd_kind_in;
   logic [7:0]        bnd_byte_ff, bnd_byte_in;
   logic [1:0]        bnd_status_ff, bnd_status_in;
   logic [31:0]       bnd_crc_ff, bnd_crc_in;
   logic [2:0]        bnd_idx_ff, bnd_idx_in;

   logic              req_accept;
   logic              rsp_take;
   logic              last_take;
   logic              trailer_hold;
   logic [POS_W-1:0]  eff_len;
   logic [31:0]       crc_step;
   logic [31:0]       trl_next;

   // Configuration writes are always taken.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_CHECK;
         record_len_ff <= RECORD_LEN_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_MODE:       mode_ff       <= csr_data[0];
            CSR_RECORD_LEN: record_len_ff <= csr_data;
            default:        mode_ff       <= mode_ff;
         endcase
      end
   end

   // Clamp the record length into the supported range.
   always_comb begin
      if (record_len_ff == 13'd0) begin
         eff_len = POS_W'(1);
      end else if (32'(record_len_ff) > 32'(MAX_RECORD_LEN)) begin
         eff_len = POS_W'(MAX_RECORD_LEN);
      end else begin
         eff_len = POS_W'(record_len_ff);
      end
   end

   // Handshakes: the result register frees up when its last beat leaves.
   assign rsp_valid  = bnd_valid_ff;
   assign rsp_take   = rsp_valid && !rsp_stall;
   assign last_take  = rsp_take && rsp_data.last;
   assign req_stall  = bnd_valid_ff && !last_take;
   assign req_accept = req_valid && !req_stall;

   assign crc_step = crc_byte(crc_ff, req_data.data_byte);
   assign trl_next = {req_data.data_byte, trl_ff[31:8]};

   // Record state update and the results for the incoming beat.
   always_comb begin
      crc_in        = crc_ff;
      pos_in        = pos_ff;
      trl_in        = trl_ff;
      trailer_hold  = 1'b0;
      bnd_kind_in   = BND_DATA;
      bnd_byte_in   = req_data.data_byte;
      bnd_status_in = STATUS_OK;
      bnd_crc_in    = '0;
      if (req_data.end_of_stream) begin
         bnd_kind_in = BND_STATUS;
         bnd_byte_in = '0;
         if (pos_ff == '0) begin
            bnd_status_in = STATUS_CLEAN;
         end else begin
            bnd_status_in = STATUS_CORRUPT;
            bnd_crc_in    = crc_ff ^ CRC_ONES;
         end
         crc_in = CRC_ONES;
         pos_in = '0;
         trl_in = '0;
      end else if (mode_ff == MODE_APPEND) begin
         crc_in = crc_step;
         if (pos_ff >= eff_len - POS_W'(1)) begin
            // Last payload byte: the trailer follows the echo.
            bnd_kind_in = BND_CRC;
            bnd_crc_in  = crc_step ^ CRC_ONES;
            crc_in      = CRC_ONES;
            pos_in      = '0;
            trl_in      = '0;
         end else begin
            pos_in = pos_ff + POS_W'(1);
         end
      end else if (pos_ff < eff_len) begin
         crc_in = crc_step;
         pos_in = pos_ff + POS_W'(1);
      end else begin
         // Trailer byte in check mode; the fourth one closes the record.
         trl_in = trl_next;
         if (pos_ff - eff_len >= POS_W'(3)) begin
            bnd_kind_in   = BND_STATUS;
            bnd_byte_in   = '0;
            bnd_status_in = ((crc_ff ^ CRC_ONES) == trl_next) ? STATUS_OK : STATUS_CORRUPT;
            bnd_crc_in    = crc_ff ^ CRC_ONES;
            crc_in        = CRC_ONES;
            pos_in        = '0;
            trl_in        = '0;
         end else begin
            // Earlier trailer bytes are only collected.
            trailer_hold = 1'b1;
            pos_in       = pos_ff + POS_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff <= CRC_ONES;
         pos_ff <= '0;
         trl_ff <= '0;
      end else if (req_accept) begin
         crc_ff <= crc_in;
         pos_ff <= pos_in;
         trl_ff <= trl_in;
      end
   end

   // Result register control: load on accept, step through beats on take.
   always_comb begin
      bnd_valid_in = bnd_valid_ff;
      bnd_idx_in   = bnd_idx_ff;
      if (req_accept) begin
         bnd_valid_in = !trailer_hold;
         bnd_idx_in   = '0;
      end else if (last_take) begin
         bnd_valid_in = 1'b0;
         bnd_idx_in   = '0;
      end else if (rsp_take) begin
         bnd_idx_in = bnd_idx_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bnd_valid_ff <= 1'b0;
         bnd_idx_ff   <= '0;
      end else begin
         bnd_valid_ff <= bnd_valid_in;
         bnd_idx_ff   <= bnd_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         bnd_kind_ff   <= bnd_kind_in;
         bnd_byte_ff   <= bnd_byte_in;
         bnd_status_ff <= bnd_status_in;
         bnd_crc_ff    <= bnd_crc_in;
      end
   end

   // Pick the result beat out of the pending entry.
   always_comb begin
      rsp_data = '0;
      if (bnd_kind_ff == BND_STATUS) begin
         rsp_data.kind      = KIND_STATUS;
         rsp_data.status    = bnd_status_ff;
         rsp_data.crc_value = bnd_crc_ff;
         rsp_data.last      = 1'b1;
      end else begin
         rsp_data.kind = KIND_DATA;
         case (bnd_idx_ff)
            3'd0: begin
               rsp_data.out_byte = bnd_byte_ff;
               rsp_data.last     = (bnd_kind_ff == BND_DATA);
            end
            3'd1: begin
               rsp_data.out_byte  = bnd_crc_ff[7:0];
               rsp_data.crc_value = bnd_crc_ff;
            end
            3'd2: begin
               rsp_data.out_byte  = bnd_crc_ff[15:8];
               rsp_data.crc_value = bnd_crc_ff;
            end
            3'd3: begin
               rsp_data.out_byte  = bnd_crc_ff[23:16];
               rsp_data.crc_value = bnd_crc_ff;
            end
            default: begin
               rsp_data.out_byte  = bnd_crc_ff[31:24];
               rsp_data.crc_value = bnd_crc_ff;
               rsp_data.last      = 1'b1;
            end
         endcase
      end
   end

   // An accepted beat that gives a result always leaves it pending.
   `CRCRF_ASSERT_NEXT(a_accept_loads, clock, reset, req_accept && !trailer_hold, rsp_valid)
   // Only an appended trailer walks past the first beat.
   `CRCRF_ASSERT_IMPLY(a_idx_only_crc, clock, reset, bnd_valid_ff && bnd_idx_ff != 3'd0,
      bnd_kind_ff == BND_CRC)
   // Taking the last beat with nothing arriving empties the result register.
   `CRCRF_ASSERT_NEXT(a_drain_empties, clock, reset, last_take && !req_valid, !rsp_valid)

endmodule

`default_nettype wire

// ===== tb/crcrf_result_checker.sv =====
`default_nettype none

// CRC arithmetic shared by the stimulus and the checker.
package crc_bench_pkg;
   import crcrf_pkg::*;

   // Advance a reflected CRC-32 register by one byte, one bit at a time.
   function automatic logic [31:0] crc32_step(input logic [31:0] acc, input logic [7:0] octet);
      logic [31:0] r;
      r = acc;
      for (int k = 0; k < 8; k++) begin
         r = (r >> 1) ^ ((r[0] ^ octet[k]) ? CRC_POLY : 32'd0);
      end
      return r;
   endfunction

endpackage

// Watches all three channels, predicts the result beats of every accepted
// input beat and compares them in order against what the block delivers.
module crcrf_result_checker
   import crcrf_pkg::*;
   import crc_bench_pkg::*;
#(
   parameter int MAX_LEN = 4096
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   input  wire logic          req_stall,
   input  wire crcrf_req_type req_data,
   input  wire logic          rsp_valid,
   input  wire logic          rsp_stall,
   input  wire crcrf_rsp_type rsp_data,
   input  wire logic          csr_valid,
   input  wire logic          csr_ready,
   input  wire logic          csr_index,
   input  wire logic [12:0]   csr_data,
   output int                 error_count,
   output int                 pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   // Shadow copy of the registers and the record state.
   logic          cfg_mode;
   logic [12:0]   cfg_len;
   logic [31:0]   crc_acc;
   logic [12:0]   rec_pos;
   logic [31:0]   trailer_bytes;
   crcrf_rsp_type expected_beats[$];

   // Payload length as the block applies it, clamped to the legal range.
   function automatic int span_of(input logic [12:0] len);
      if (len == 13'd0) return 1;
      if (int'(len) > MAX_LEN) return MAX_LEN;
      return int'(len);
   endfunction

   task automatic clear_record();
      crc_acc       = CRC_ONES;
      rec_pos       = '0;
      trailer_bytes = '0;
   endtask

   // One line per mismatch, and the count goes up.
   task automatic report_mismatch(input string what, input logic [31:0] want,
                                  input logic [31:0] got);
      $display("%0t ns: mismatch on %s, expected %0h, got %0h", $time, what, want, got);
      error_count++;
   endtask

   // Work out the result beats caused by one accepted input beat.
   task automatic predict_results(input crcrf_req_type beat);
      crcrf_rsp_type outs[5];
      crcrf_rsp_type one;
      logic [31:0]   fin;
      int            n;
      int            span;
      n    = 0;
      span = span_of(cfg_len);
      one  = '0;
      one.kind = KIND_DATA;
      if (beat.end_of_stream) begin
         // End of stream: clean at a boundary, truncated anywhere else.
         one.kind = KIND_STATUS;
         if (rec_pos == 13'd0) begin
            one.status = STATUS_CLEAN;
         end else begin
            one.status    = STATUS_CORRUPT;
            one.crc_value = ~crc_acc;
         end
         outs[0] = one;
         n = 1;
         clear_record();
      end else if (cfg_mode == MODE_APPEND) begin
         // Echo the byte; the last payload byte is followed by the four CRC bytes.
         crc_acc      = crc32_step(crc_acc, beat.data_byte);
         one.out_byte = beat.data_byte;
         outs[0]      = one;
         n = 1;
         if (int'(rec_pos) + 1 >= span) begin
            fin = ~crc_acc;
            for (int i = 0; i < 4; i++) begin
               one.out_byte  = fin[8*i +: 8];
               one.crc_value = fin;
               outs[n] = one;
               n++;
            end
            clear_record();
         end else begin
            rec_pos++;
         end
      end else if (int'(rec_pos) < span) begin
         // Check mode, payload byte: echo it.
         crc_acc      = crc32_step(crc_acc, beat.data_byte);
         one.out_byte = beat.data_byte;
         outs[0]      = one;
         n = 1;
         rec_pos++;
      end else begin
         // Check mode, trailer byte: shifted in from the top, judged on the fourth.
         trailer_bytes = {beat.data_byte, trailer_bytes[31:8]};
         if (int'(rec_pos) - span >= 3) begin
            fin           = ~crc_acc;
            one.kind      = KIND_STATUS;
            one.status    = (fin == trailer_bytes) ? STATUS_OK : STATUS_CORRUPT;
            one.crc_value = fin;
            outs[0]       = one;
            n = 1;
            clear_record();
         end else begin
            rec_pos++;
         end
      end
      for (int i = 0; i < n; i++) begin
         one      = outs[i];
         one.last = (i == n - 1);
         expected_beats.push_back(one);
      end
   endtask

   // Compare one delivered result beat with the oldest expectation.
   task automatic check_result(input crcrf_rsp_type got);
      crcrf_rsp_type want;
      if (expected_beats.size() == 0) begin
         report_mismatch("result beat with nothing expected", 32'd0, got.crc_value);
         return;
      end
      want = expected_beats.pop_front();
      if (got.kind !== want.kind) begin
         report_mismatch("kind", 32'(want.kind), 32'(got.kind));
      end
      if (got.out_byte !== want.out_byte) begin
         report_mismatch("out_byte", 32'(want.out_byte), 32'(got.out_byte));
      end
      if (got.status !== want.status) begin
         report_mismatch("status", 32'(want.status), 32'(got.status));
      end
      if (got.crc_value !== want.crc_value) begin
         report_mismatch("crc_value", want.crc_value, got.crc_value);
      end
      if (got.last !== want.last) begin
         report_mismatch("last", 32'(want.last), 32'(got.last));
      end
   endtask

   // Results are compared before the same edge's input is predicted, since a
   // result beat never leaves in the cycle its input beat is accepted.
   always @(posedge clock) begin
      if (reset) begin
         cfg_mode = MODE_CHECK;
         cfg_len  = RECORD_LEN_RESET;
         clear_record();
         expected_beats.delete();
         error_count   = 0;
         pending_count = 0;
      end else begin
         if (rsp_valid && !rsp_stall) check_result(rsp_data);
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_MODE) begin
               cfg_mode = csr_data[0];
            end else begin
               cfg_len = csr_data;
            end
         end
         if (req_valid && !req_stall) predict_results(req_data);
         pending_count = expected_beats.size();
      end
   end

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`default_nettype none

module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import crcrf_pkg::*;
   import crc_bench_pkg::*;

   localparam int MAX_LEN        = 4096;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int HOLD_CYCLES    = 60;
   localparam int DRAIN_CYCLES   = 4;
   localparam int NO_FLIP        = -1;

   // Payload fill patterns.
   localparam int PAY_RANDOM = 0;
   localparam int PAY_ZERO   = 1;
   localparam int PAY_ONES   = 2;

   logic          clock       = 1'b0;
   logic          reset       = 1'b1;
   logic          req_valid   = 1'b0;
   logic          req_stall;
   crcrf_req_type req_data    = '0;
   logic          rsp_valid;
   logic          rsp_stall   = 1'b0;
   crcrf_rsp_type rsp_data;
   logic          csr_valid   = 1'b0;
   logic          csr_ready;
   logic          csr_index   = CSR_MODE;
   logic [12:0]   csr_data    = '0;

   int errors;
   int pending_results;
   int send_idle_pct   = 29;
   int recv_idle_pct   = 74;
   int holds_requested = 0;
   int holds_served    = 0;
   int quiet_cycles    = 0;

   // Stimulus-side view of the configuration.
   logic cur_mode = MODE_CHECK;
   int   cur_eff  = 64;

   always #5 clock = ~clock;

   crc32_record_framer_checker #(
      .MAX_RECORD_LEN(MAX_LEN)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data (csr_data)
   );

   crcrf_result_checker #(
      .MAX_LEN(MAX_LEN)
   ) u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .error_count  (errors),
      .pending_count(pending_results)
   );

   // Receiver: random stalls, or a long hold-off when one is requested.
   initial begin
      forever begin
         @(negedge clock);
         if (holds_served != holds_requested) begin
            holds_served++;
            rsp_stall = 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         rsp_stall = ($urandom_range(99) < recv_idle_pct);
      end
   end

   // Watchdog: ends the run if no channel moves a beat for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Offer one input beat, with random idle cycles first, and wait until it is taken.
   task automatic send_beat(input logic [7:0] b, input logic eos);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid              = 1'b1;
      req_data.data_byte     = b;
      req_data.end_of_stream = eos;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic send_noise(input int count);
      for (int i = 0; i < count; i++) send_beat(8'($urandom), 1'b0);
   endtask

   // One record; in check mode its trailer follows, optionally with one bit flipped.
   task automatic send_record(input int len, input int style, input int flip);
      logic [31:0] acc;
      logic [31:0] seal;
      logic [7:0]  b;
      acc = CRC_ONES;
      for (int i = 0; i < len; i++) begin
         case (style)
            PAY_ZERO: b = 8'h00;
            PAY_ONES: b = 8'hFF;
            default:  b = 8'($urandom);
         endcase
         acc = crc32_step(acc, b);
         send_beat(b, 1'b0);
      end
      if (cur_mode == MODE_CHECK) begin
         seal = ~acc;
         if (flip >= 0) seal[flip] = ~seal[flip];
         for (int i = 0; i < 4; i++) send_beat(seal[8*i +: 8], 1'b0);
      end
   endtask

   // Stop sending and wait until every expected result is out, plus a few
   // cycles for trailer bytes that cause no result.
   task automatic quiesce();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_results != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic idx, input logic [12:0] val);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = val;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic configure(input logic mode, input logic [12:0] len);
      quiesce();
      write_reg(CSR_MODE, {12'd0, mode});
      write_reg(CSR_RECORD_LEN, len);
      cur_mode = mode;
      cur_eff  = (len == 13'd0) ? 1 : ((int'(len) > MAX_LEN) ? MAX_LEN : int'(len));
   endtask

   // Mostly well-formed records with random content, some with a damaged
   // trailer, plus truncated records and bare end-of-stream beats.
   task automatic random_stream(input int quota);
      int sent;
      int roll;
      int total;
      int cut;
      sent = 0;
      while (sent < quota) begin
         roll  = $urandom_range(99);
         total = cur_eff + ((cur_mode == MODE_CHECK) ? 4 : 0);
         if (roll < 80) begin
            send_record(cur_eff, PAY_RANDOM,
                        ($urandom_range(3) == 0) ? int'($urandom_range(31)) : NO_FLIP);
            sent += total;
         end else begin
            if (roll < 92 && total > 1) begin
               cut = $urandom_range(1, total - 1);
               send_noise(cut);
               sent += cut;
            end
            send_beat(8'($urandom), 1'b1);
            sent++;
         end
      end
   endtask

   initial begin
      logic [12:0] len_cfg;

      repeat (4) @(negedge clock);
      reset = 1'b0;

      // Check mode: a good record, a damaged one, then a clean end.
      configure(MODE_CHECK, 13'd2);
      send_record(2, PAY_ZERO, NO_FLIP);
      send_record(2, PAY_ONES, 31);
      send_beat(8'hA5, 1'b1);

      // Append mode with a zero length, which acts as one byte per record.
      configure(MODE_APPEND, 13'd0);
      send_beat(8'hFF, 1'b0);
      send_beat(8'h00, 1'b0);
      send_beat(8'h5A, 1'b1);

      // End of stream inside a payload, then inside a trailer.
      configure(MODE_APPEND, 13'd3);
      send_noise(1);
      send_beat(8'($urandom), 1'b1);
      configure(MODE_CHECK, 13'd2);
      send_noise(3);
      send_beat(8'($urandom), 1'b1);

      // Length shrinks in the middle of a record, in both modes.
      configure(MODE_CHECK, 13'd4);
      send_noise(3);
      quiesce();
      write_reg(CSR_RECORD_LEN, 13'd1);
      send_noise(2);
      configure(MODE_APPEND, 13'd6);
      send_noise(2);
      quiesce();
      write_reg(CSR_RECORD_LEN, 13'd2);
      send_noise(1);

      // Random part in three idling phases; a long receiver hold-off in two of them.
      for (int ph = 0; ph < 3; ph++) begin
         quiesce();
         case (ph)
            0: begin
               send_idle_pct = 29;
               recv_idle_pct = 74;
            end
            1: begin
               send_idle_pct = 74;
               recv_idle_pct = 29;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         for (int s = 0; s < 2; s++) begin
            len_cfg = ($urandom_range(7) == 0) ? 13'd0 : 13'($urandom_range(1, 6));
            configure(1'($urandom_range(1)), len_cfg);
            if (s == 0 && ph != 1) holds_requested++;
            random_stream(18);
         end
      end

      // Over-range length: it clamps to the maximum, so short streams end truncated.
      configure(MODE_APPEND, 13'h1FFF);
      send_noise(5);
      send_beat(8'($urandom), 1'b1);
      configure(MODE_CHECK, 13'h1FFF);
      send_noise(5);
      send_beat(8'($urandom), 1'b1);

      quiesce();
      repeat (8) @(negedge clock);
      if (errors == 0 && pending_results == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire
